[hdl/png_chunk_stream_parser_top_defines.svh]
// ---------------------------------------------------------------------------
// PNG chunk parser assertion macros
// Concurrent assertion wrappers, empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef PNG_CHUNK_STREAM_PARSER_TOP_DEFINES_SVH
`define PNG_CHUNK_STREAM_PARSER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PCP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`else
`define PCP_ASSERT(label, clk, rst_n, prop)
`endif
`endif

[hdl/pcsp_pkg.sv]
// ---------------------------------------------------------------------------
// PNG chunk parser package
// Phase codes, status and event codes, CRC-32 byte update.
// ---------------------------------------------------------------------------
package pcsp_pkg;

    localparam logic [3:0] PH_SIG       = 4'd0;
    localparam logic [3:0] PH_HDR       = 4'd1;
    localparam logic [3:0] PH_IHDR      = 4'd2;
    localparam logic [3:0] PH_SKIP_DATA = 4'd3;
    localparam logic [3:0] PH_SKIP_CRC  = 4'd4;
    localparam logic [3:0] PH_HAND_DATA = 4'd5;
    localparam logic [3:0] PH_HAND_CRC  = 4'd6;
    localparam logic [3:0] PH_END_DATA  = 4'd7;
    localparam logic [3:0] PH_END_CRC   = 4'd8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_BAD_HDR   = 3'd3;
    localparam logic [2:0] ST_MISS_HDR  = 3'd4;
    localparam logic [2:0] ST_BAD_SUM   = 3'd5;
    localparam logic [2:0] ST_CRIT      = 3'd6;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_HEADER    = 3'd1;
    localparam logic [2:0] EV_START     = 3'd2;
    localparam logic [2:0] EV_DATA      = 3'd3;
    localparam logic [2:0] EV_FINISH    = 3'd4;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
    localparam logic [7:0]  ANC_BIT   = 8'h20;
    localparam logic [31:0] IHDR_LEN  = 32'd13;
    localparam logic [63:0] SIGNATURE = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic        finish_ok;
        logic [31:0] chunk_type;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  sample_depth;
        logic [7:0]  colour_mode;
        logic [7:0]  compression_method;
        logic [7:0]  filter_method;
        logic [7:0]  interlace_method;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

[hdl/pcsp_core.sv]
// ---------------------------------------------------------------------------
// PNG chunk parser core
// Parse state and per-byte next-state / result logic.
// ---------------------------------------------------------------------------
module pcsp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_in,
    input  logic [31:0]       handled_type_a,
    input  logic [31:0]       handled_type_b,
    output pcsp_pkg::result_t res
);
    import pcsp_pkg::*;

    logic [3:0]   phase_reg, phase_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [63:0]  buf_reg, buf_next;
    logic [31:0]  left_reg, left_next;
    logic [31:0]  crc_reg, crc_next;
    logic         seen_reg, seen_next;
    logic [2:0]   sticky_reg, sticky_next;
    logic [31:0]  act_reg, act_next;
    logic [95:0]  hdr_reg, hdr_next;   // first 12 header bytes

    logic [63:0]  shifted;
    logic [31:0]  t, len, crc_b, left_dec, crc_t;
    logic         handled, ok;
    logic [3:0]   cnt_inc;

    assign shifted  = {buf_reg[55:0], data_in};
    assign t        = shifted[31:0];
    assign len      = shifted[63:32];
    assign cnt_inc  = cnt_reg + 4'd1;
    assign crc_b    = crc_byte(crc_reg, data_in);
    assign crc_t    = crc_byte(crc_byte(crc_byte(crc_byte(32'hFFFF_FFFF,
                      t[31:24]), t[23:16]), t[15:8]), t[7:0]);
    assign left_dec = (left_reg != 32'd0) ? left_reg - 32'd1 : 32'd0;
    assign handled  = (handled_type_a != 32'd0 && t == handled_type_a) ||
                      (handled_type_b != 32'd0 && t == handled_type_b);
    assign ok       = shifted[31:0] == ~crc_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        buf_next    = buf_reg;
        left_next   = left_reg;
        crc_next    = crc_reg;
        seen_next   = seen_reg;
        sticky_next = sticky_reg;
        act_next    = act_reg;
        hdr_next    = hdr_reg;
        res         = '0;
        if (sticky_reg != ST_OK)
        begin
            res.status = sticky_reg;
        end
        else
        begin
            unique case (phase_reg)
                PH_SIG:
                begin
                    buf_next = shifted;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 4'd8)
                    begin
                        cnt_next = 4'd0;
                        if (shifted != SIGNATURE) res.status = ST_BAD_SIG;
                        else phase_next = PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    buf_next = shifted;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 4'd8)
                    begin
                        cnt_next  = 4'd0;
                        crc_next  = crc_t;
                        left_next = len;
                        if (!seen_reg)
                        begin
                            if (t != TYPE_IHDR) res.status = ST_MISS_HDR;
                            else if (len != IHDR_LEN) res.status = ST_BAD_HDR;
                            else
                            begin
                                seen_next  = 1'b1;
                                phase_next = PH_IHDR;
                            end
                        end
                        else if (t == TYPE_IEND)
                            phase_next = (len != 32'd0) ? PH_END_DATA : PH_END_CRC;
                        else if (handled)
                        begin
                            act_next       = t;
                            res.event_res  = EV_START;
                            res.chunk_type = t;
                            phase_next = (len != 32'd0) ? PH_HAND_DATA : PH_HAND_CRC;
                        end
                        else if ((t[31:24] & ANC_BIT) == 8'd0)
                            res.status = ST_CRIT;
                        else
                            phase_next = (len != 32'd0) ? PH_SKIP_DATA : PH_SKIP_CRC;
                    end
                end
                PH_IHDR:
                begin
                    crc_next = crc_b;
                    hdr_next = {hdr_reg[87:0], data_in};
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 4'd13)
                    begin
                        cnt_next                = 4'd0;
                        res.event_res           = EV_HEADER;
                        res.image_width         = hdr_reg[95:64];
                        res.image_height        = hdr_reg[63:32];
                        res.sample_depth        = hdr_reg[31:24];
                        res.colour_mode         = hdr_reg[23:16];
                        res.compression_method  = hdr_reg[15:8];
                        res.filter_method       = hdr_reg[7:0];
                        res.interlace_method    = data_in;
                        phase_next              = PH_SKIP_CRC;
                    end
                end
                PH_SKIP_DATA, PH_HAND_DATA, PH_END_DATA:
                begin
                    crc_next = crc_b;
                    if (phase_reg == PH_HAND_DATA)
                    begin
                        res.event_res  = EV_DATA;
                        res.data_byte  = data_in;
                        res.chunk_type = act_reg;
                    end
                    left_next = left_dec;
                    if (left_dec == 32'd0) phase_next = phase_reg + 4'd1;
                end
                PH_SKIP_CRC, PH_HAND_CRC, PH_END_CRC:
                begin
                    buf_next = shifted;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 4'd4)
                    begin
                        cnt_next = 4'd0;
                        if (phase_reg == PH_HAND_CRC)
                        begin
                            res.event_res  = EV_FINISH;
                            res.finish_ok  = ok;
                            res.chunk_type = act_reg;
                        end
                        if (!ok) res.status = ST_BAD_SUM;
                        else if (phase_reg == PH_END_CRC) res.status = ST_DONE;
                        else phase_next = PH_HDR;
                    end
                end
                default:
                begin
                    phase_next = PH_SIG;
                    cnt_next   = 4'd0;
                end
            endcase
            sticky_next = res.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            cnt_reg    <= 4'd0;
            buf_reg    <= 64'd0;
            left_reg   <= 32'd0;
            crc_reg    <= 32'hFFFF_FFFF;
            seen_reg   <= 1'b0;
            sticky_reg <= ST_OK;
            act_reg    <= 32'd0;
            hdr_reg    <= 96'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            buf_reg    <= buf_next;
            left_reg   <= left_next;
            crc_reg    <= crc_next;
            seen_reg   <= seen_next;
            sticky_reg <= sticky_next;
            act_reg    <= act_next;
            hdr_reg    <= hdr_next;
        end
    end

`include "png_chunk_stream_parser_top_defines.svh"
    `PCP_ASSERT(a_sticky_holds, clk, rst_n, (sticky_reg != ST_OK) |=> $stable(sticky_reg))
    `PCP_ASSERT(a_cnt_range, clk, rst_n, cnt_reg < 4'd13)
    `PCP_ASSERT(a_phase_range, clk, rst_n, phase_reg <= PH_END_CRC)

endmodule

[hdl/png_chunk_stream_parser_top.sv]
// ---------------------------------------------------------------------------
// PNG chunk stream parser
// Byte-wide PNG signature, chunk framing and CRC-32 checker.
// ---------------------------------------------------------------------------
// Use: bytes of a PNG file enter on data_in with valid/ready; each accepted
// item gives exactly one result item on the output channel (status, event
// and header/chunk fields). Handler types are set through cfg_we/cfg_index/
// cfg_data while idle; index 0 is handled_type_a, index 1 handled_type_b.
// Latency: a result is valid the cycle after its byte is accepted.
// Throughput: one byte per cycle while results are taken; the CRC byte update
// and the phase logic sit between the parse state and the result register.
// The result register is the only buffer: ready is high whenever it is empty
// or being drained, so a stalled receiver holds the result and stops input.
// Reset: asynchronous, clears the parse state to expect the signature and
// clears both handler registers; no result is pending after reset.
// Once a nonzero status (done or an error) is given, every later item
// returns that status with no event.
// ---------------------------------------------------------------------------
module png_chunk_stream_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [2:0]  event_res,
    output logic [7:0]  data_byte,
    output logic        finish_ok,
    output logic [31:0] chunk_type,
    output logic [31:0] image_width,
    output logic [31:0] image_height,
    output logic [7:0]  sample_depth,
    output logic [7:0]  colour_mode,
    output logic [7:0]  compression_method,
    output logic [7:0]  filter_method,
    output logic [7:0]  interlace_method,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import pcsp_pkg::*;

    localparam logic CFG_TYPE_A = 1'b0;
    localparam logic CFG_TYPE_B = 1'b1;

    logic [31:0] type_a_reg, type_b_reg;
    logic        vld_reg;
    result_t     res, res_reg;
    logic        step;

    assign in_ready = !vld_reg || out_ready;
    assign step     = in_valid && in_ready;

    pcsp_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .data_in        (data_in),
        .handled_type_a (type_a_reg),
        .handled_type_b (type_b_reg),
        .res            (res)
    );

    // handler type registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_a_reg <= 32'd0;
            type_b_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TYPE_A: type_a_reg <= cfg_data;
                CFG_TYPE_B: type_b_reg <= cfg_data;
                default:    type_a_reg <= type_a_reg;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign out_valid          = vld_reg;
    assign status             = res_reg.status;
    assign event_res          = res_reg.event_res;
    assign data_byte          = res_reg.data_byte;
    assign finish_ok          = res_reg.finish_ok;
    assign chunk_type         = res_reg.chunk_type;
    assign image_width        = res_reg.image_width;
    assign image_height       = res_reg.image_height;
    assign sample_depth       = res_reg.sample_depth;
    assign colour_mode        = res_reg.colour_mode;
    assign compression_method = res_reg.compression_method;
    assign filter_method      = res_reg.filter_method;
    assign interlace_method   = res_reg.interlace_method;

`include "png_chunk_stream_parser_top_defines.svh"
    `PCP_ASSERT(a_hold_stall, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
    `PCP_ASSERT(a_step_fills, clk, rst_n, step |=> out_valid)
    `PCP_ASSERT(a_no_take_stalled, clk, rst_n, (out_valid && !out_ready) |-> !in_ready)

endmodule
